FILE: design/assert_macros.svh
// Concurrent check helpers, sampled on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is disabled while rst_n is low.
`define CHK_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check that also covers the reset cycles.
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: design/chash_pkg.sv
package chash_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam int COUNT_W = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam int CMD_Q_DEPTH = 4;
  localparam int RES_Q_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic        opcode;
    logic [31:0] object_id;
    logic [31:0] object_handle;
    logic [15:0] grid_cell;
  } item_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] handle;
    logic [15:0] grid_cell;
  } entry_t;

  typedef struct packed {
    status_t             status;
    logic [31:0]         found_handle;
    logic [15:0]         found_cell;
    logic [COUNT_W-1:0]  entry_total;
  } result_t;

endpackage

FILE: design/chash_fifo.sv
module chash_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW:0]      count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: design/chash_front.sv
module chash_front import chash_pkg::*; #(
  parameter  int NUM_BUCKETS = 1024,
  localparam int BKT_W       = $clog2(NUM_BUCKETS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  item_t            in_item,
  output logic             ready,
  input  logic             q_full,
  output logic             q_push,
  output logic [BKT_W-1:0] q_bucket,
  output item_t            q_item
);

  // bucket = id mod N via reciprocal: qhat is floor(id/N) or one less,
  // so the remainder lands in [0, 2N) and one subtract fixes it.
  localparam int          RW       = BKT_W + 1;
  localparam logic [63:0] RECIP64  = (64'd1 << 32) / NUM_BUCKETS;
  localparam logic [31:0] RECIP    = RECIP64[31:0];
  localparam logic [RW-1:0] N_RW   = RW'(NUM_BUCKETS);

  logic          v1_r, v2_r, v3_r;
  item_t         s1_item_r, s2_item_r, s3_item_r;
  logic [31:0]   s2_qhat_r;
  logic [RW-1:0] s3_rem_r;

  logic          en;
  logic [63:0]   prod;
  logic [31:0]   qhat_nxt;
  logic [RW-1:0] qn;
  logic [RW-1:0] rem_nxt;
  logic [RW-1:0] rem_fix;

  assign en       = !v3_r || !q_full;
  assign ready    = en;
  assign prod     = 64'(s1_item_r.object_id) * 64'(RECIP);
  assign qhat_nxt = prod[63:32];
  assign qn       = s2_qhat_r[RW-1:0] * N_RW;
  assign rem_nxt  = s2_item_r.object_id[RW-1:0] - qn;
  assign rem_fix  = (s3_rem_r >= N_RW) ? s3_rem_r - N_RW : s3_rem_r;

  assign q_push   = v3_r && !q_full;
  assign q_bucket = rem_fix[BKT_W-1:0];
  assign q_item   = s3_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r <= in_item;
      s2_item_r <= s1_item_r;
      s2_qhat_r <= qhat_nxt;
      s3_item_r <= s2_item_r;
      s3_rem_r  <= rem_nxt;
    end
  end

endmodule

FILE: design/chash_back.sv
module chash_back import chash_pkg::*; #(
  parameter  int NUM_BUCKETS  = 1024,
  parameter  int BUCKET_DEPTH = 4,
  localparam int BKT_W        = $clog2(NUM_BUCKETS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_empty,
  output logic             cmd_pop,
  input  logic [BKT_W-1:0] cmd_bucket,
  input  item_t            cmd_item,
  input  logic             res_full,
  output logic             res_push,
  output result_t          res_word,
  output logic             clearing
);

  localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
  localparam int SLOT_W = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_FETCH,
    S_EXEC
  } state_t;

  state_t                    state_r;
  logic [BKT_W-1:0]          clr_idx_r;
  item_t                     item_r;
  logic [BKT_W-1:0]          bkt_r;
  logic [COUNT_W-1:0]        count_r;

  logic [FILL_W-1:0]         fill_mem [NUM_BUCKETS];
  entry_t [BUCKET_DEPTH-1:0] slot_mem [NUM_BUCKETS];
  logic [FILL_W-1:0]         fill_rd_r;
  entry_t [BUCKET_DEPTH-1:0] row_rd_r;

  logic                      exec_go;
  logic                      is_ins;
  logic                      bucket_full;
  logic                      wr_en;
  logic [SLOT_W-1:0]         wr_slot;
  entry_t                    new_entry;
  logic                      hit;
  logic [31:0]               hit_handle;
  logic [15:0]               hit_cell;
  logic [COUNT_W-1:0]        count_nxt;

  assign clearing    = (state_r == S_CLEAR);
  assign cmd_pop     = (state_r == S_FETCH) && !cmd_empty;
  assign exec_go     = (state_r == S_EXEC) && !res_full;
  assign is_ins      = (item_r.opcode == OP_INSERT);
  assign bucket_full = (fill_rd_r >= FILL_W'(BUCKET_DEPTH));
  assign wr_en       = exec_go && is_ins && !bucket_full;
  assign wr_slot     = fill_rd_r[SLOT_W-1:0];

  assign new_entry.key       = item_r.object_id;
  assign new_entry.handle    = item_r.object_handle;
  assign new_entry.grid_cell = item_r.grid_cell;

  // newest match wins: later slots override earlier ones
  always_comb begin
    hit        = 1'b0;
    hit_handle = '0;
    hit_cell   = '0;
    for (int i = 0; i < BUCKET_DEPTH; i++) begin
      if ((FILL_W'(i) < fill_rd_r) && (row_rd_r[i].key == item_r.object_id)) begin
        hit        = 1'b1;
        hit_handle = row_rd_r[i].handle;
        hit_cell   = row_rd_r[i].grid_cell;
      end
    end
  end

  assign count_nxt = (wr_en && (count_r != COUNT_MAX)) ? count_r + 1'b1 : count_r;

  always_comb begin
    res_word.entry_total  = count_nxt;
    res_word.found_handle = '0;
    res_word.found_cell   = '0;
    if (is_ins) begin
      res_word.status = bucket_full ? ST_FULL : ST_OK;
    end else if (hit) begin
      res_word.status       = ST_OK;
      res_word.found_handle = hit_handle;
      res_word.found_cell   = hit_cell;
    end else begin
      res_word.status = ST_NOT_FOUND;
    end
  end

  assign res_push = exec_go;

  always_ff @(posedge clk) begin
    if (clearing) begin
      fill_mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      fill_mem[bkt_r] <= FILL_W'(fill_rd_r + 1'b1);
    end
    if (cmd_pop) begin
      fill_rd_r <= fill_mem[cmd_bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[bkt_r][wr_slot] <= new_entry;
    end
    if (cmd_pop) begin
      row_rd_r <= slot_mem[cmd_bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
      count_r   <= '0;
    end else begin
      count_r <= count_nxt;
      case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == BKT_W'(NUM_BUCKETS - 1)) begin
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          if (cmd_pop) begin
            item_r  <= cmd_item;
            bkt_r   <= cmd_bucket;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            state_r <= S_FETCH;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

endmodule

FILE: design/chained_hash_table.sv
// Hash table of fixed-depth buckets keyed by a 32-bit object id.
// Input side is a queue: drive opcode (0 insert, 1 lookup), object_id,
// object_handle and grid_cell with push; the word is taken on a clock
// edge where push is high and full is low.
// Result side is a queue too: while empty is low the oldest result word
// (status, found_handle, found_cell, entry_total) sits on the out_ ports and
// is taken on an edge where pop is high. Each input word yields one result.
// Bucket = object_id mod NUM_BUCKETS, worked out by a three-stage
// reciprocal pipeline in the front; a four-entry queue feeds the back.
// The back takes each word through a fetch state that reads the bucket row
// and fill count from block RAM, then an exec state that compares all slots
// and writes back an insert; it fetches no new word until the exec state has
// pushed the result, which waits while the result queue is full.
// Reset (rst_n low, synchronous) empties both queues, zeroes the entry count
// and starts a sweep that clears the fill count of every bucket, one per
// cycle; full stays high until it is done.
// If the receiver stops popping, the two-entry result queue fills, the back
// stalls, the command queue fills and full rises; nothing is dropped.
`include "assert_macros.svh"

module chained_hash_table import chash_pkg::*; #(
  parameter int NUM_BUCKETS  = 1024,
  parameter int BUCKET_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_opcode,
  input  logic [31:0]        in_object_id,
  input  logic [31:0]        in_object_handle,
  input  logic [15:0]        in_grid_cell,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         out_status,
  output logic [31:0]        out_found_handle,
  output logic [15:0]        out_found_cell,
  output logic [COUNT_W-1:0] out_entry_total
);

  localparam int BKT_W   = $clog2(NUM_BUCKETS);
  localparam int ITEM_W  = $bits(item_t);
  localparam int CMD_W   = BKT_W + ITEM_W;
  localparam int RES_W   = $bits(result_t);

  item_t            in_item;
  logic             accept;
  logic             front_ready;
  logic             clearing;

  // front -> command queue
  logic             cmd_push;
  logic             cmd_full;
  logic [BKT_W-1:0] front_bucket;
  item_t            front_item;
  logic [CMD_W-1:0] cmd_din;

  // command queue -> back
  logic             cmd_pop;
  logic             cmd_empty;
  logic [CMD_W-1:0] cmd_dout;
  logic [BKT_W-1:0] cmd_bucket;
  item_t            cmd_item;

  // back -> result queue
  logic             res_push;
  logic             res_full;
  result_t          res_word;
  logic [RES_W-1:0] res_dout;
  result_t          out_word;

  assign in_item.opcode        = in_opcode;
  assign in_item.object_id     = in_object_id;
  assign in_item.object_handle = in_object_handle;
  assign in_item.grid_cell     = in_grid_cell;

  // no words while the fill store is being swept
  assign full   = !front_ready || clearing;
  assign accept = push && !full;

  chash_front #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_item  (in_item),
    .ready    (front_ready),
    .q_full   (cmd_full),
    .q_push   (cmd_push),
    .q_bucket (front_bucket),
    .q_item   (front_item)
  );

  assign cmd_din = {front_bucket, front_item};

  chash_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_din),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_dout),
    .empty (cmd_empty)
  );

  assign cmd_bucket = cmd_dout[CMD_W-1:ITEM_W];
  assign cmd_item   = item_t'(cmd_dout[ITEM_W-1:0]);

  chash_back #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .cmd_bucket (cmd_bucket),
    .cmd_item   (cmd_item),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_word   (res_word),
    .clearing   (clearing)
  );

  chash_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_word),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_dout),
    .empty (empty)
  );

  assign out_word         = result_t'(res_dout);
  assign out_status       = out_word.status;
  assign out_found_handle = out_word.found_handle;
  assign out_found_cell   = out_word.found_cell;
  assign out_entry_total  = out_word.entry_total;

  // sweep runs only before any word gets in
  `CHK_RUN(a_clear_cmd_empty, clearing |-> cmd_empty, "command queue busy during sweep")
  // back must wait on result space, front on command space
  `CHK_RUN(a_res_room, res_push |-> !res_full, "result pushed into full queue")
  `CHK_RUN(a_cmd_room, cmd_push |-> !cmd_full, "command pushed into full queue")
  // a reset cycle leaves no stale result behind
  `CHK_ALWAYS(a_rst_empty, !rst_n |=> empty, "result queue not empty after reset")

endmodule

FILE: tb/chash_checker.sv
module chash_checker import chash_pkg::*; #(
  parameter int NUM_BUCKETS  = 1024,
  parameter int BUCKET_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  logic               in_opcode,
  input  logic [31:0]        in_object_id,
  input  logic [31:0]        in_object_handle,
  input  logic [15:0]        in_grid_cell,
  input  logic               empty,
  input  logic               pop,
  input  logic [1:0]         out_status,
  input  logic [31:0]        out_found_handle,
  input  logic [15:0]        out_found_cell,
  input  logic [COUNT_W-1:0] out_entry_total,
  output int                 fail_cnt,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow table
  int unsigned        fill_cnt [NUM_BUCKETS];
  entry_t             slot_mem [NUM_BUCKETS*BUCKET_DEPTH];
  logic [COUNT_W-1:0] entry_count;

  result_t            expected_q [$];
  result_t            want;
  int                 errs;

  initial begin
    errs = 0;
  end

  task automatic report_mismatch(input string what);
    if (errs < 40) $display("mismatch @%0t: %s", $realtime, what);
    errs++;
  endtask

  // Updates the shadow table with one word and returns the result it causes.
  function automatic result_t apply_word(input logic op, input logic [31:0] id,
                                         input logic [31:0] handle,
                                         input logic [15:0] grid_cell);
    int unsigned bkt;
    int unsigned base;
    int unsigned fill;
    int          i;
    logic        hit;
    result_t     r;
    r      = '0;
    r.status = ST_OK;
    bkt    = id % NUM_BUCKETS;
    base   = bkt * BUCKET_DEPTH;
    fill   = fill_cnt[bkt];
    if (fill > BUCKET_DEPTH) fill = BUCKET_DEPTH;
    if (op == OP_INSERT) begin
      if (fill >= BUCKET_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        slot_mem[base + fill] = '{key: id, handle: handle, grid_cell: grid_cell};
        fill_cnt[bkt] = fill + 1;
        if (entry_count != COUNT_MAX) entry_count++;
      end
    end else begin
      // newest entry first, so the latest duplicate wins
      hit = 1'b0;
      for (i = int'(fill) - 1; i >= 0 && !hit; i--) begin
        if (slot_mem[base + i].key == id) begin
          hit            = 1'b1;
          r.found_handle = slot_mem[base + i].handle;
          r.found_cell   = slot_mem[base + i].grid_cell;
        end
      end
      if (!hit) r.status = ST_NOT_FOUND;
    end
    r.entry_total = entry_count;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NUM_BUCKETS; b++) fill_cnt[b] = 0;
      entry_count = '0;
      expected_q.delete();
    end else begin
      if (push && !full)
        expected_q.push_back(apply_word(in_opcode, in_object_id, in_object_handle,
                                        in_grid_cell));
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result word with no input word pending");
        end else begin
          want = expected_q.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
          if (out_found_handle !== want.found_handle)
            report_mismatch($sformatf("found_handle got %h want %h",
                                      out_found_handle, want.found_handle));
          if (out_found_cell !== want.found_cell)
            report_mismatch($sformatf("found_cell got %h want %h",
                                      out_found_cell, want.found_cell));
          if (out_entry_total !== want.entry_total)
            report_mismatch($sformatf("entry_total got %0d want %0d",
                                      out_entry_total, want.entry_total));
        end
      end
    end
    pending  <= expected_q.size();
    fail_cnt <= errs;
  end

endmodule

FILE: tb/tb_top.sv
module tb_top;
  import chash_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BUCKETS  = 1024;
  localparam int BUCKET_DEPTH = 4;
  localparam int RAND_WORDS   = 1600;

  // Everything the block sees has a known value from time zero.
  logic               clk              = 1'b0;
  logic               rst_n            = 1'b0;
  logic               push             = 1'b0;
  logic               in_opcode        = OP_INSERT;
  logic [31:0]        in_object_id     = '0;
  logic [31:0]        in_object_handle = '0;
  logic [15:0]        in_grid_cell     = '0;
  logic               pop              = 1'b0;
  logic               full;
  logic               empty;
  logic [1:0]         out_status;
  logic [31:0]        out_found_handle;
  logic [15:0]        out_found_cell;
  logic [COUNT_W-1:0] out_entry_total;

  // High while both sides run without idle cycles.
  logic               steady = 1'b0;

  int                 fail_cnt;
  int                 pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  chained_hash_table #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .BUCKET_DEPTH(BUCKET_DEPTH)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_opcode       (in_opcode),
    .in_object_id    (in_object_id),
    .in_object_handle(in_object_handle),
    .in_grid_cell    (in_grid_cell),
    .empty           (empty),
    .pop             (pop),
    .out_status      (out_status),
    .out_found_handle(out_found_handle),
    .out_found_cell  (out_found_cell),
    .out_entry_total (out_entry_total)
  );

  chash_checker #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .BUCKET_DEPTH(BUCKET_DEPTH)
  ) u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_opcode       (in_opcode),
    .in_object_id    (in_object_id),
    .in_object_handle(in_object_handle),
    .in_grid_cell    (in_grid_cell),
    .empty           (empty),
    .pop             (pop),
    .out_status      (out_status),
    .out_found_handle(out_found_handle),
    .out_found_cell  (out_found_cell),
    .out_entry_total (out_entry_total),
    .fail_cnt        (fail_cnt),
    .pending         (pending)
  );

  // Result side: pop is dropped at random, with odds of 17 in 100, never during the steady stretch.
  // Held low through reset; nothing is taken during the clearing sweep, as the result queue is empty then.
  always @(negedge clk) begin
    pop <= rst_n && (steady || $urandom_range(0, 99) >= 17);
  end

  // Offers one word and returns at the falling edge after it was taken.
  // push stays high from word to word unless an idle cycle is drawn, so
  // back-to-back words never see push dropped and raised in one step.
  task automatic send_word(input logic op, input logic [31:0] id,
                           input logic [31:0] handle, input logic [15:0] grid_cell);
    while (!steady && $urandom_range(0, 99) < 17) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push             <= 1'b1;
    in_opcode        <= op;
    in_object_id     <= id;
    in_object_handle <= handle;
    in_grid_cell     <= grid_cell;
    // full is read before the edge updates it: taken when it was low
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  initial begin
    logic [31:0] hi_pool [4];
    logic [31:0] recent_ids [$];
    logic [31:0] id;
    logic        op;
    int unsigned win_base;
    int unsigned bkt;
    int unsigned pick;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // --- directed words ---
    // extremes of every field, hit and miss in the same bucket
    send_word(OP_INSERT, 32'h0000_0000, 32'h0000_0000, 16'h0000);
    send_word(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF);  // handle/cell ignored
    send_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000);
    send_word(OP_LOOKUP, 32'h0000_0400, 32'h0, 16'h0);            // bucket 0, other key
    send_word(OP_LOOKUP, 32'h1234_5677, 32'h0, 16'h0);            // bucket never used
    // bucket 5: duplicate key, then fill it and try one more
    send_word(OP_INSERT, 32'h0000_0005, 32'hAAAA_0001, 16'h0001);
    send_word(OP_INSERT, 32'h0000_0405, 32'hBBBB_0002, 16'h0002);
    send_word(OP_INSERT, 32'h0000_0005, 32'hCCCC_0003, 16'h0003);
    send_word(OP_INSERT, 32'hFFFF_FC05, 32'hDDDD_0004, 16'h0004);
    send_word(OP_INSERT, 32'h0000_0805, 32'hEEEE_0005, 16'h0005); // refused, bucket full
    send_word(OP_LOOKUP, 32'h0000_0005, 32'h0, 16'h0);            // newest duplicate
    send_word(OP_LOOKUP, 32'h0000_0405, 32'h0, 16'h0);
    send_word(OP_LOOKUP, 32'hFFFF_FC05, 32'h0, 16'h0);
    send_word(OP_LOOKUP, 32'h0000_0805, 32'h0, 16'h0);            // never stored
    send_word(OP_INSERT, 32'hFFFF_FFFF, 32'h5A5A_A5A5, 16'hA5A5); // duplicate of top key
    send_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 16'h0);
    send_word(OP_LOOKUP, 32'h8000_0000, 32'h0, 16'h0);

    // --- random words ---
    // Keys crowd a handful of buckets in a window that moves every 64 words,
    // so buckets fill, overflow and hold duplicates; lookups mostly go after
    // recently inserted keys. About one word in ten has a fully random id.
    win_base = 0;
    for (int n = 0; n < RAND_WORDS; n++) begin
      steady <= (n >= 700 && n < 1000);
      if (n % 64 == 0) begin
        win_base = $urandom_range(0, NUM_BUCKETS - 1);
        foreach (hi_pool[k]) hi_pool[k] = $urandom;
        recent_ids.delete();
      end
      op = ($urandom_range(0, 1) == 0) ? OP_INSERT : OP_LOOKUP;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        id = $urandom;
      end else if (op == OP_LOOKUP && recent_ids.size() != 0 && pick < 70) begin
        id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
      end else begin
        bkt = (win_base + $urandom_range(0, 5)) % NUM_BUCKETS;
        id  = hi_pool[$urandom_range(0, 3)] * NUM_BUCKETS + bkt;
      end
      if (op == OP_INSERT) begin
        recent_ids.push_back(id);
        if (recent_ids.size() > 16) void'(recent_ids.pop_front());
      end
      send_word(op, id, $urandom, 16'($urandom_range(0, 65535)));
    end
    push   <= 1'b0;
    steady <= 1'b0;

    // drain, then keep watching for stray result words
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, clearing sweep included.
  initial begin
    #3ms;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/chash_pkg.sv
design/chash_fifo.sv
design/chash_front.sv
design/chash_back.sv
design/chained_hash_table.sv
tb/chash_checker.sv
tb/tb_top.sv
